@@ hw/rtl/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types for the bounded deque engine: operation and status codes,
// the sequencer states and the port widths.
// ----------------------------------------------------------------------------
package bdq_pkg;

	typedef enum logic [2:0] {
		OP_PUT_BACK  = 3'd0,
		OP_PUT_FRONT = 3'd1,
		OP_GET_BACK  = 3'd2,
		OP_GET_FRONT = 3'd3,
		OP_READ      = 3'd4,
		OP_WRITE     = 3'd5,
		OP_INSERT    = 3'd6,
		OP_ERASE     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_FINAL,
		S_DONE
	} state_t;

	localparam int unsigned DATA_PORT_W  = 32;
	localparam int unsigned POS_PORT_W   = 9;
	localparam int unsigned COUNT_PORT_W = 9;

endpackage

@@ hw/rtl/bounded_deque_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Fixed-capacity double-ended queue kept in one circular RAM, with a front
// pointer and an element count in registers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req_valid/req_ready with operation, value and position;
//   each request gives exactly one response on rsp_valid/rsp_ready carrying
//   data, status and count.
//   Push, pop, read and write take one RAM access: the request moves to the
//   done state, where the response is registered, and the next request is
//   taken only once the engine is back in idle.
//   Insert and erase move entries one place per cycle through the RAM
//   (read one entry, write it one slot further back in the next cycle):
//   the request passes through the shift state, which moves n entries, then
//   the final and done states, where the response is registered; n is the
//   number of entries moved (count - position for insert, position for
//   erase). With nothing to move the shift state is skipped. The single
//   RAM write port sets that pace, and the next request waits for idle.
//   Rejected requests (full, empty, out of range) change nothing and go
//   straight to the done state like a push.
//   Reset empties the deque at once; RAM contents are not cleared, and only
//   live entries are ever read.
//   A new request is taken while the previous response still waits in the
//   output register; if the receiver stalls, the following request parks in
//   its done state until the output register frees up.
// ----------------------------------------------------------------------------
module bounded_deque_engine #(
	parameter int unsigned DEPTH      = 256,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  operation,
	input  logic [31:0] value,
	input  logic [8:0]  position,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] data,
	output logic [1:0]  status,
	output logic [8:0]  count
);

	import bdq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > POS_PORT_W) ? CW : POS_PORT_W;
	localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] a);
		return (a == '0) ? LAST_SLOT : a - AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
		return (a == LAST_SLOT) ? '0 : a + AW'(1);
	endfunction

	// control state
	state_t        state_q, state_d;
	logic [AW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic          rd_s1;
	logic          out_valid_q;

	// request payload and shift pointers
	op_t             op_q;
	status_t         stat_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [AW-1:0]   src_q;
	logic [AW-1:0]   dst_q;
	logic [CW-1:0]   n_rd_q;
	logic [CW-1:0]   n_wr_q;

	// output register
	logic [31:0] data_q;
	status_t     stat_out_q;
	logic [8:0]  count_out_q;

	// RAM port
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// request decode
	op_t                   op_in;
	logic [XW-1:0]         pos_x;
	logic [XW-1:0]         cnt_x;
	logic                  is_full;
	logic                  is_empty;
	status_t               stat_c;
	logic [AW-1:0]         lidx_c;
	logic [AW:0]           sum_c;
	logic [AW-1:0]         slot_c;
	logic [AW-1:0]         addr_c;
	logic [CW-1:0]         nshift_c;
	logic [63:0]           val64;
	logic [DATA_WIDTH-1:0] val_c;
	logic                  xfer_in;
	logic                  req_ok;
	logic                  load_out;
	logic [63:0]           rd64;

	assign op_in    = op_t'(operation);
	assign pos_x    = XW'(position);
	assign cnt_x    = XW'(count_q);
	assign is_full  = (count_q == DEPTH_C);
	assign is_empty = (count_q == '0);
	assign val64    = 64'(value);
	assign val_c    = val64[DATA_WIDTH-1:0];
	assign rd64     = 64'(ram_rdata);

	always_comb begin
		stat_c = STAT_OK;
		case (op_in)
			OP_PUT_BACK, OP_PUT_FRONT: begin
				if (is_full) stat_c = STAT_FULL;
			end
			OP_GET_BACK, OP_GET_FRONT: begin
				if (is_empty) stat_c = STAT_EMPTY;
			end
			OP_INSERT: begin
				if (pos_x > cnt_x) stat_c = STAT_RANGE;
				else if (is_full) stat_c = STAT_FULL;
			end
			default: begin
				if (pos_x >= cnt_x) stat_c = STAT_RANGE;
			end
		endcase
	end

	// logical index from the front, only meaningful when the request is valid
	always_comb begin
		case (op_in)
			OP_PUT_BACK, OP_INSERT: lidx_c = AW'(count_q);
			OP_GET_BACK:            lidx_c = AW'(count_q - CW'(1));
			default:                lidx_c = pos_x[AW-1:0];
		endcase
	end

	assign sum_c  = {1'b0, front_q} + {1'b0, lidx_c};
	assign slot_c = (sum_c >= DEPTH_S) ? AW'(sum_c - DEPTH_S) : sum_c[AW-1:0];

	always_comb begin
		case (op_in)
			OP_PUT_FRONT: addr_c = slot_dec(front_q);
			OP_GET_FRONT: addr_c = front_q;
			default:      addr_c = slot_c;
		endcase
	end

	assign nshift_c = (op_in == OP_INSERT) ? count_q - CW'(pos_x) : CW'(pos_x);

	assign xfer_in  = req_valid && req_ready;
	assign req_ok   = (stat_c == STAT_OK);
	assign load_out = (state_q == S_DONE) && (!out_valid_q || rsp_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_ok && (op_in == OP_INSERT || op_in == OP_ERASE)) begin
						state_d = (nshift_c != '0) ? S_SHIFT : S_FINAL;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SHIFT: begin
				if (rd_s1 && n_wr_q == CW'(1)) state_d = S_FINAL;
			end
			S_FINAL: state_d = S_DONE;
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs and RAM control
	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = dst_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = addr_c;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid && req_ok) begin
					case (op_in)
						OP_PUT_BACK, OP_PUT_FRONT, OP_WRITE: begin
							ram_we    = 1'b1;
							ram_waddr = addr_c;
							ram_wdata = val_c;
						end
						OP_GET_BACK, OP_GET_FRONT, OP_READ: begin
							ram_re = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_SHIFT: begin
				ram_re    = (n_rd_q != '0);
				ram_raddr = slot_dec(src_q);
				ram_we    = rd_s1;
			end
			S_FINAL: begin
				ram_we    = (op_q == OP_INSERT);
				ram_wdata = val_q;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == S_SHIFT) && (n_rd_q != '0);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (xfer_in && req_ok) begin
				case (op_in)
					OP_PUT_BACK: count_q <= count_q + CW'(1);
					OP_PUT_FRONT: begin
						front_q <= slot_dec(front_q);
						count_q <= count_q + CW'(1);
					end
					OP_GET_BACK: count_q <= count_q - CW'(1);
					OP_GET_FRONT: begin
						front_q <= slot_inc(front_q);
						count_q <= count_q - CW'(1);
					end
					default: ;
				endcase
			end
			if (state_q == S_FINAL) begin
				if (op_q == OP_INSERT) begin
					count_q <= count_q + CW'(1);
				end else begin
					front_q <= slot_inc(front_q);
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer_in) begin
			op_q   <= op_in;
			stat_q <= stat_c;
			val_q  <= val_c;
			src_q  <= addr_c;
			dst_q  <= addr_c;
			n_rd_q <= nshift_c;
			n_wr_q <= nshift_c;
		end
		if (state_q == S_SHIFT) begin
			if (n_rd_q != '0) begin
				src_q  <= slot_dec(src_q);
				n_rd_q <= n_rd_q - CW'(1);
			end
			if (rd_s1) begin
				dst_q  <= slot_dec(dst_q);
				n_wr_q <= n_wr_q - CW'(1);
			end
		end
		if (load_out) begin
			stat_out_q  <= stat_q;
			count_out_q <= COUNT_PORT_W'(count_q);
			if (stat_q == STAT_OK &&
			    (op_q == OP_GET_BACK || op_q == OP_GET_FRONT || op_q == OP_READ)) begin
				data_q <= rd64[DATA_PORT_W-1:0];
			end else begin
				data_q <= '0;
			end
		end
	end

	bdq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rsp_valid = out_valid_q;
	assign data      = data_q;
	assign status    = stat_out_q;
	assign count     = count_out_q;

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("element count above capacity");

	// the shift never reads the entry it writes in the same cycle
	a_shift_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && ram_re && ram_we) |-> (ram_raddr != ram_waddr))
		else $error("shift read and write hit the same entry");

	// the front pointer holds while entries are being moved
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |=> $stable(front_q))
		else $error("front pointer moved during shift");

	// a response is only loaded from the done state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside the done state");

endmodule

@@ hw/rtl/bdq_ram.sv @@
// ----------------------------------------------------------------------------
// bdq_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module bdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ bench/bounded_deque_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_checker
// Watches the request and response channels of the bounded deque engine,
// keeps a shadow deque, predicts one response per request transfer and
// compares every response transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_deque_checker
	import bdq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_ready,
	input  op_t                     operation,
	input  logic [DATA_PORT_W-1:0]  value,
	input  logic [POS_PORT_W-1:0]   position,
	input  logic                    rsp_valid,
	input  logic                    rsp_ready,
	input  logic [DATA_PORT_W-1:0]  data,
	input  logic [1:0]              status,
	input  logic [COUNT_PORT_W-1:0] count,
	output int                      fail_count,
	output int                      pending
);

	localparam int DEPTH = 256;
	localparam int EXP_SLOTS = 16;

	typedef struct packed {
		logic [DATA_PORT_W-1:0]  data;
		status_t                 status;
		logic [COUNT_PORT_W-1:0] count;
	} deque_result_t;

	logic [DATA_PORT_W-1:0]  shadow_store [DEPTH];
	logic [7:0]              shadow_front = '0;
	logic [COUNT_PORT_W-1:0] shadow_count = '0;

	// predictions in transfer order, oldest at exp_rd
	deque_result_t           expected_buf [EXP_SLOTS];
	int                      exp_rd = 0;
	int                      exp_wr = 0;
	int                      exp_level = 0;
	int                      fails = 0;

	assign fail_count = fails;

	// logical index from the front to physical slot, wrapping at the depth
	function automatic logic [7:0] physical_slot(logic [8:0] idx);
		return shadow_front + idx[7:0];
	endfunction

	task automatic predict_deque_op(input op_t op, input logic [DATA_PORT_W-1:0] val,
			input logic [8:0] pos, output deque_result_t res);
		logic [8:0] i;
		res.data = '0;
		res.status = STAT_OK;
		case (op)
			OP_PUT_BACK: begin
				if (shadow_count == DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					shadow_store[physical_slot(shadow_count)] = val;
					shadow_count++;
				end
			end
			OP_PUT_FRONT: begin
				if (shadow_count == DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					shadow_front--;
					shadow_store[shadow_front] = val;
					shadow_count++;
				end
			end
			OP_GET_BACK: begin
				if (shadow_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					shadow_count--;
					res.data = shadow_store[physical_slot(shadow_count)];
				end
			end
			OP_GET_FRONT: begin
				if (shadow_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					res.data = shadow_store[shadow_front];
					shadow_front++;
					shadow_count--;
				end
			end
			OP_READ: begin
				if (pos >= shadow_count) res.status = STAT_RANGE;
				else res.data = shadow_store[physical_slot(pos)];
			end
			OP_WRITE: begin
				if (pos >= shadow_count) res.status = STAT_RANGE;
				else shadow_store[physical_slot(pos)] = val;
			end
			OP_INSERT: begin
				// range is judged before fullness
				if (pos > shadow_count) begin
					res.status = STAT_RANGE;
				end else if (shadow_count == DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					for (i = shadow_count; i > pos; i--)
						shadow_store[physical_slot(i)] = shadow_store[physical_slot(i - 1)];
					shadow_store[physical_slot(pos)] = val;
					shadow_count++;
				end
			end
			default: begin
				// erase: entries ahead of the hole move one place toward the back
				if (pos >= shadow_count) begin
					res.status = STAT_RANGE;
				end else begin
					for (i = pos; i > 0; i--)
						shadow_store[physical_slot(i)] = shadow_store[physical_slot(i - 1)];
					shadow_front++;
					shadow_count--;
				end
			end
		endcase
		res.count = shadow_count;
	endtask

	always @(posedge clk) begin : watch
		deque_result_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (exp_level == 0) begin
					$error("response with nothing outstanding: data %h status %0d count %0d",
						data, status, count);
					fails++;
				end else begin
					want = expected_buf[exp_rd];
					exp_rd = (exp_rd + 1) % EXP_SLOTS;
					exp_level--;
					if (data !== want.data) begin
						$error("data mismatch: expected %h, actual %h", want.data, data);
						fails++;
					end
					if (status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d", want.status, status);
						fails++;
					end
					if (count !== want.count) begin
						$error("count mismatch: expected %0d, actual %0d", want.count, count);
						fails++;
					end
				end
			end
			if (req_valid && req_ready) begin
				predict_deque_op(operation, value, position, want);
				if (exp_level == EXP_SLOTS) begin
					$error("more than %0d responses outstanding", EXP_SLOTS);
					fails++;
				end else begin
					expected_buf[exp_wr] = want;
					exp_wr = (exp_wr + 1) % EXP_SLOTS;
					exp_level++;
				end
			end
		end
		pending <= exp_level;
	end

endmodule

@@ bench/bounded_deque_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_deque_engine_tb
// Drives requests into the bounded deque engine: a directed pass over the
// empty and out-of-range cases, then random traffic that fills the
// deque, mixes all operations and drains it again, with bursty idling on the
// sender and stalls on the receiver. The checker beside the block scores it.
// ----------------------------------------------------------------------------
module bounded_deque_engine_tb;
	import bdq_pkg::*;

	localparam int DEPTH          = 256;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int QUIET_TAIL     = 150;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef enum {FILL_UP, MIXED, DRAIN_OUT} traffic_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    req_valid;
	logic                    req_ready;
	op_t                     operation;
	logic [DATA_PORT_W-1:0]  value;
	logic [POS_PORT_W-1:0]   position;
	logic                    rsp_valid;
	logic                    rsp_ready;
	logic [DATA_PORT_W-1:0]  data;
	logic [1:0]              status;
	logic [COUNT_PORT_W-1:0] count;
	int                      check_fails;
	int                      outstanding;

	// stimulus side view of the occupancy, used to aim positions and switch traffic modes
	int level;
	int idle_pct;
	int stall_pct;
	bit quiet;
	int op_hits [8];
	int full_hits;
	int empty_hits;
	int stuck_cycles;

	bounded_deque_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (operation),
		.value     (value),
		.position  (position),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.data      (data),
		.status    (status),
		.count     (count)
	);

	bounded_deque_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.operation  (operation),
		.value      (value),
		.position   (position),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.data       (data),
		.status     (status),
		.count      (count),
		.fail_count (check_fails),
		.pending    (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic retune_idling();
		int choices [4] = '{0, 5, 20, 50};
		idle_pct = choices[$urandom_range(0, 3)];
		stall_pct = choices[$urandom_range(0, 3)];
	endtask

	// one request transfer; called at a clock edge, returns at its transfer edge
	task automatic send_request(input op_t op, input logic [31:0] val, input logic [8:0] pos);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < idle_pct)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		value <= val;
		position <= pos;
		do @(posedge clk); while (!req_ready);
		op_hits[op]++;
		case (op)
			OP_PUT_BACK, OP_PUT_FRONT: begin
				if (level < DEPTH) level++;
				else full_hits++;
			end
			OP_GET_BACK, OP_GET_FRONT: begin
				if (level > 0) level--;
				else empty_hits++;
			end
			OP_INSERT: begin
				if (pos <= level && level < DEPTH) level++;
				else if (pos <= level) full_hits++;
			end
			OP_ERASE: if (pos < level) level--;
			default: ;
		endcase
	endtask

	// positions below valid_top are legal; some land at or past it, and a share
	// stays close to the end that needs little shifting
	function automatic logic [8:0] pick_position(int valid_top, bit cheap_at_back);
		int hi;
		int r;
		hi = (valid_top > 256) ? 256 : valid_top;
		r = $urandom_range(0, 99);
		if (valid_top == 0 || r >= 85)
			return 9'($urandom_range(hi, 256));
		if (r < 40) begin
			if (cheap_at_back)
				return 9'($urandom_range((valid_top > 8) ? valid_top - 8 : 0, valid_top - 1));
			return 9'($urandom_range(0, (valid_top > 8) ? 7 : valid_top - 1));
		end
		return 9'($urandom_range(0, valid_top - 1));
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// response side: bursts of back-pressure between ready stretches
	initial begin
		rsp_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 99) < stall_pct) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
				stuck_cycles, outstanding);
			$display("Some tests failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		traffic_mode_t mode;
		traffic_mode_t after_mix;
		int            mix_left;
		int            held;
		int            n;
		int            r;
		op_t           op;

		arst_n = 1'b0;
		req_valid <= 1'b0;
		operation <= OP_PUT_BACK;
		value <= '0;
		position <= '0;
		level = 0;
		quiet = 1'b0;
		full_hits = 0;
		empty_hits = 0;
		foreach (op_hits[i]) op_hits[i] = 0;
		idle_pct = 20;
		stall_pct = 20;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque: every request is refused
		send_request(OP_GET_BACK, 32'hDEAD_BEEF, 9'd0);
		send_request(OP_GET_FRONT, 32'h0, 9'd0);
		send_request(OP_READ, 32'h0, 9'd0);
		send_request(OP_ERASE, 32'h0, 9'd0);
		send_request(OP_WRITE, 32'h1111_1111, 9'd0);
		send_request(OP_INSERT, 32'h2222_2222, 9'd1);
		// insert at the count acts as a push at the back
		send_request(OP_INSERT, 32'hFFFF_FFFF, 9'd0);
		send_request(OP_PUT_BACK, 32'h0000_0000, 9'd0);
		// front pointer wraps below slot zero
		send_request(OP_PUT_FRONT, 32'h1234_5678, 9'd0);
		send_request(OP_PUT_BACK, 32'hA5A5_A5A5, 9'd0);
		send_request(OP_READ, 32'h0, 9'd0);
		send_request(OP_READ, 32'h0, 9'd3);
		send_request(OP_READ, 32'h0, 9'd4);
		send_request(OP_WRITE, 32'h5A5A_5A5A, 9'd1);
		send_request(OP_INSERT, 32'hC0DE_0001, 9'd2);
		send_request(OP_INSERT, 32'hC0DE_0002, 9'd5);
		send_request(OP_INSERT, 32'hC0DE_0003, 9'd256);
		send_request(OP_READ, 32'h0, 9'd255);
		send_request(OP_READ, 32'h0, 9'd256);
		send_request(OP_ERASE, 32'h0, 9'd0);
		send_request(OP_ERASE, 32'h0, 9'd4);
		send_request(OP_ERASE, 32'h0, 9'd2);
		send_request(OP_ERASE, 32'h0, 9'd256);
		send_request(OP_GET_BACK, 32'h0, 9'd0);
		send_request(OP_GET_FRONT, 32'h0, 9'd0);

		// random traffic: fill to capacity, mix, drain to empty, mix, repeat
		mode = FILL_UP;
		after_mix = DRAIN_OUT;
		mix_left = 0;
		held = 0;
		retune_idling();
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_TAIL)
				quiet = 1'b1;
			if (n == RANDOM_ITEMS / 2) begin
				// let every response drain before carrying on
				req_valid <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end
			case (mode)
				FILL_UP: begin
					if (level == DEPTH) held++;
					if (held >= 8) begin
						mode = MIXED;
						after_mix = DRAIN_OUT;
						mix_left = $urandom_range(60, 150);
						held = 0;
						retune_idling();
					end
				end
				DRAIN_OUT: begin
					if (level == 0) held++;
					if (held >= 8) begin
						mode = MIXED;
						after_mix = FILL_UP;
						mix_left = $urandom_range(60, 150);
						held = 0;
						retune_idling();
					end
				end
				default: begin
					mix_left--;
					if (mix_left <= 0) begin
						mode = after_mix;
						retune_idling();
					end
				end
			endcase
			r = $urandom_range(0, 99);
			case (mode)
				FILL_UP: op = (r < 40) ? OP_PUT_BACK : (r < 65) ? OP_PUT_FRONT :
					(r < 80) ? OP_INSERT : op_t'($urandom_range(0, 7));
				DRAIN_OUT: op = (r < 35) ? OP_GET_BACK : (r < 60) ? OP_GET_FRONT :
					(r < 75) ? OP_ERASE : op_t'($urandom_range(0, 7));
				default: op = op_t'($urandom_range(0, 7));
			endcase
			if (op == OP_INSERT)
				send_request(op, pick_value(), pick_position(level + 1, 1'b1));
			else
				send_request(op, pick_value(), pick_position(level, 1'b0));
		end
		req_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);

		$display("covered %0d requests: %0d push, %0d pop, %0d read, %0d write",
			op_hits.sum(), op_hits[OP_PUT_BACK] + op_hits[OP_PUT_FRONT],
			op_hits[OP_GET_BACK] + op_hits[OP_GET_FRONT], op_hits[OP_READ],
			op_hits[OP_WRITE]);
		$display("%0d insert, %0d erase; refused %0d at capacity, %0d pops when empty",
			op_hits[OP_INSERT], op_hits[OP_ERASE], full_hits, empty_hits);
		if (check_fails == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
